>>> rtl/core/fuhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuhs_pkg
// Shared codes, widths and transaction types of the firmware update sequencer.
// ----------------------------------------------------------------------------
package fuhs_pkg;

    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 136;
    localparam int OUT_USER_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACK_RETRIES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_START_OFFSET = 1'd1;

    // event codes
    localparam logic [3:0] FUNC_START       = 4'd0;
    localparam logic [3:0] FUNC_ACK         = 4'd1;
    localparam logic [3:0] FUNC_ACK_TIMEOUT = 4'd2;
    localparam logic [3:0] FUNC_CHUNK_REQ   = 4'd3;
    localparam logic [3:0] FUNC_END         = 4'd4;
    localparam logic [3:0] FUNC_HEARTBEAT   = 4'd5;
    localparam logic [3:0] FUNC_BEAT_TMO    = 4'd6;
    localparam logic [3:0] FUNC_ABORT       = 4'd7;
    localparam logic [3:0] FUNC_CHUNK_STAT  = 4'd8;

    // chunk status codes
    localparam logic [1:0] CST_SENT       = 2'd0;
    localparam logic [1:0] CST_FLASH_FAIL = 2'd1;
    localparam logic [1:0] CST_SEND_FAIL  = 2'd2;

    // result actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_REQUEST   = 3'd1;
    localparam logic [2:0] ACT_HEARTBEAT = 3'd2;
    localparam logic [2:0] ACT_CHUNK     = 3'd3;
    localparam logic [2:0] ACT_FINISHED  = 3'd4;
    localparam logic [2:0] ACT_ERROR     = 3'd5;
    localparam logic [2:0] ACT_IDLE      = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT = 3'd1;
    localparam logic [2:0] ERR_FLASH   = 3'd2;
    localparam logic [2:0] ERR_SEND    = 3'd3;
    localparam logic [2:0] ERR_CLIENT  = 3'd4;

    // timer commands
    localparam logic [1:0] TMR_KEEP  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // sequencer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REQ  = 2'd1;
    localparam logic [1:0] MODE_UPD  = 2'd2;
    localparam logic [1:0] MODE_ERR  = 2'd3;

    localparam logic [7:0] RETRY_MAX   = 8'hFF;
    localparam logic [7:0] RETRY_RESET = 8'd5;

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] img_len;
        logic [15:0] chunk_cap;
        logic [63:0] client_node;
        logic        ok_flag;
        logic [7:0]  client_error;
        logic [1:0]  chunk_status;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic        last;
        logic [63:0] dest_node;
        logic [31:0] chunk_offset;
        logic [15:0] chunk_bytes;
        logic [2:0]  error_code;
        logic [7:0]  reported_error;
        logic        success;
        logic [1:0]  ack_timer_cmd;
        logic [1:0]  beat_timer_cmd;
        logic        overall_timer_stop;
        logic [1:0]  mode;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage
`default_nettype wire

>>> rtl/core/fuhs_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuhs_in_stage
// Input register: holds one event transaction until the step logic takes it.
// ----------------------------------------------------------------------------
module fuhs_in_stage (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [fuhs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire  [fuhs_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  wire                                i_take,
    output logic                               o_valid,
    output fuhs_pkg::t_in_item                 o_item
);
    import fuhs_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     in_acc;

    assign s_axis_tready = !r_valid || i_take;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.func         <= s_axis_tuser;
            r_item.img_len      <= s_axis_tdata[31:0];
            r_item.chunk_cap    <= s_axis_tdata[47:32];
            r_item.client_node  <= s_axis_tdata[111:48];
            r_item.ok_flag      <= s_axis_tdata[112];
            r_item.client_error <= s_axis_tdata[120:113];
            r_item.chunk_status <= s_axis_tdata[122:121];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

>>> rtl/core/fuhs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuhs_step
// Sequencer state, configuration registers and the per-event result logic.
// ----------------------------------------------------------------------------
module fuhs_step (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [fuhs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [fuhs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                i_fire,
    input  fuhs_pkg::t_in_item                 i_item,
    output fuhs_pkg::t_push                    o_push
);
    import fuhs_pkg::*;

    logic [7:0]  r_max_retries;
    logic [31:0] r_start_offset;
    logic [1:0]  r_mode;
    logic [7:0]  r_retry;
    logic [31:0] r_total;
    logic [15:0] r_max_chunk;
    logic [63:0] r_peer;
    logic [31:0] r_remaining;
    logic [15:0] r_pending;

    logic [1:0]  n_mode;
    logic [7:0]  n_retry;
    logic [31:0] n_total;
    logic [15:0] n_max_chunk;
    logic [63:0] n_peer;
    logic [31:0] n_remaining;
    logic [15:0] n_pending;

    logic [1:0]  nres;
    t_result     res0;
    t_result     res1;
    logic [7:0]  retry_inc;
    logic [15:0] chunk_len;
    logic [31:0] chunk_off;

    assign retry_inc = (r_retry == RETRY_MAX) ? r_retry : r_retry + 8'd1;
    assign chunk_len = (r_remaining >= {16'd0, r_max_chunk}) ? r_max_chunk
                                                             : r_remaining[15:0];
    assign chunk_off = r_start_offset + r_total - r_remaining;

    always_comb begin
        n_mode      = r_mode;
        n_retry     = r_retry;
        n_total     = r_total;
        n_max_chunk = r_max_chunk;
        n_peer      = r_peer;
        n_remaining = r_remaining;
        n_pending   = r_pending;
        nres        = 2'd0;
        res0        = '0;
        res1        = '0;
        res0.last   = 1'b1;
        res1.last   = 1'b1;
        case (i_item.func)
            FUNC_START: begin
                if (r_mode == MODE_IDLE || r_mode == MODE_ERR) begin
                    n_total            = i_item.img_len;
                    n_max_chunk        = i_item.chunk_cap;
                    n_peer             = i_item.client_node;
                    n_remaining        = i_item.img_len;
                    n_pending          = 16'd0;
                    n_retry            = 8'd0;
                    n_mode             = MODE_REQ;
                    nres               = 2'd1;
                    res0.action        = ACT_REQUEST;
                    res0.dest_node     = i_item.client_node;
                    res0.ack_timer_cmd = TMR_START;
                end
            end
            FUNC_ACK: begin
                if (r_mode == MODE_REQ) begin
                    nres               = 2'd1;
                    res0.ack_timer_cmd = TMR_STOP;
                    if (i_item.ok_flag) begin
                        n_mode              = MODE_UPD;
                        res0.action         = ACT_NONE;
                        res0.beat_timer_cmd = TMR_START;
                    end else begin
                        n_mode              = MODE_ERR;
                        res0.action         = ACT_ERROR;
                        res0.error_code     = ERR_CLIENT;
                        res0.reported_error = i_item.client_error;
                    end
                end
            end
            FUNC_ACK_TIMEOUT: begin
                if (r_mode == MODE_REQ) begin
                    n_retry = retry_inc;
                    nres    = 2'd1;
                    if (retry_inc >= r_max_retries) begin
                        n_mode             = MODE_ERR;
                        res0.action        = ACT_ERROR;
                        res0.error_code    = ERR_TIMEOUT;
                        res0.ack_timer_cmd = TMR_STOP;
                    end else begin
                        res0.action        = ACT_REQUEST;
                        res0.dest_node     = r_peer;
                        res0.ack_timer_cmd = TMR_START;
                    end
                end
            end
            FUNC_CHUNK_REQ: begin
                if (r_mode == MODE_UPD) begin
                    n_pending           = chunk_len;
                    nres                = 2'd2;
                    res0.action         = ACT_HEARTBEAT;
                    res0.dest_node      = r_peer;
                    res0.beat_timer_cmd = TMR_STOP;
                    res0.last           = 1'b0;
                    res1.action         = ACT_CHUNK;
                    res1.dest_node      = r_peer;
                    res1.chunk_offset   = chunk_off;
                    res1.chunk_bytes    = chunk_len;
                    res1.beat_timer_cmd = TMR_START;
                end
            end
            FUNC_CHUNK_STAT: begin
                if (r_mode == MODE_UPD) begin
                    case (i_item.chunk_status) inside
                        CST_SENT: begin
                            n_remaining = (r_remaining >= {16'd0, r_pending})
                                        ? r_remaining - {16'd0, r_pending} : 32'd0;
                            n_pending   = 16'd0;
                            nres        = 2'd1;
                            res0.action = ACT_NONE;
                        end
                        CST_FLASH_FAIL, CST_SEND_FAIL: begin
                            n_mode              = MODE_ERR;
                            nres                = 2'd1;
                            res0.action         = ACT_ERROR;
                            res0.error_code     = (i_item.chunk_status == CST_FLASH_FAIL)
                                                ? ERR_FLASH : ERR_SEND;
                            res0.beat_timer_cmd = TMR_STOP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FUNC_END: begin
                if (r_mode == MODE_UPD) begin
                    n_mode                  = MODE_IDLE;
                    nres                    = 2'd1;
                    res0.action             = ACT_FINISHED;
                    res0.success            = i_item.ok_flag;
                    res0.beat_timer_cmd     = TMR_STOP;
                    res0.overall_timer_stop = 1'b1;
                end
            end
            FUNC_HEARTBEAT: begin
                if (r_mode == MODE_UPD) begin
                    nres                = 2'd1;
                    res0.action         = ACT_NONE;
                    res0.beat_timer_cmd = TMR_START;
                end
            end
            FUNC_BEAT_TMO: begin
                if (r_mode == MODE_UPD) begin
                    n_mode              = MODE_ERR;
                    nres                = 2'd1;
                    res0.action         = ACT_ERROR;
                    res0.error_code     = ERR_TIMEOUT;
                    res0.beat_timer_cmd = TMR_STOP;
                end
            end
            FUNC_ABORT: begin
                if (r_mode == MODE_REQ) begin
                    n_mode             = MODE_ERR;
                    nres               = 2'd1;
                    res0.action        = ACT_ERROR;
                    res0.error_code    = ERR_TIMEOUT;
                    res0.ack_timer_cmd = TMR_STOP;
                end else if (r_mode == MODE_UPD) begin
                    n_mode              = MODE_IDLE;
                    nres                = 2'd1;
                    res0.action         = ACT_IDLE;
                    res0.beat_timer_cmd = TMR_STOP;
                end
            end
            default: begin
            end
        endcase
        res0.mode = n_mode;
        res1.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries  <= RETRY_RESET;
            r_start_offset <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ACK_RETRIES:    r_max_retries  <= i_cfg_data[7:0];
                CFG_IMAGE_START_OFFSET: r_start_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_retry     <= 8'd0;
            r_total     <= 32'd0;
            r_max_chunk <= 16'd0;
            r_peer      <= 64'd0;
            r_remaining <= 32'd0;
            r_pending   <= 16'd0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_retry     <= n_retry;
            r_total     <= n_total;
            r_max_chunk <= n_max_chunk;
            r_peer      <= n_peer;
            r_remaining <= n_remaining;
            r_pending   <= n_pending;
        end
    end

    assign o_push.count = i_fire ? nres : 2'd0;
    assign o_push.res0  = res0;
    assign o_push.res1  = res1;

endmodule
`default_nettype wire

>>> rtl/core/fuhs_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuhs_out_queue
// Three-slot ordered result buffer in front of the master-side stream.
// ----------------------------------------------------------------------------
module fuhs_out_queue (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  fuhs_pkg::t_push                    i_push,
    output logic                               o_room,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [fuhs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [fuhs_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast
);
    import fuhs_pkg::*;

    t_result    r_q [3];
    t_result    n_q [3];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] base;
    logic       pop;

    assign pop    = (r_cnt != 2'd0) && m_axis_tready;
    assign base   = r_cnt - {1'b0, pop};
    assign n_cnt  = base + i_push.count;
    assign o_room = (r_cnt <= 2'd1);

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];
        for (int i = 0; i < 3; i++) begin
            if (i_push.count != 2'd0 && base == 2'(i)) begin
                n_q[i] = i_push.res0;
            end
            if (i_push.count == 2'd2 && base + 2'd1 == 2'(i)) begin
                n_q[i] = i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = r_q[0].action;
    assign m_axis_tlast  = r_q[0].last;
    assign m_axis_tdata  = {5'd0,
                            r_q[0].mode,
                            r_q[0].overall_timer_stop,
                            r_q[0].beat_timer_cmd,
                            r_q[0].ack_timer_cmd,
                            r_q[0].success,
                            r_q[0].reported_error,
                            r_q[0].error_code,
                            r_q[0].chunk_bytes,
                            r_q[0].chunk_offset,
                            r_q[0].dest_node};

endmodule
`default_nettype wire

>>> rtl/core/firmware_update_host_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firmware_update_host_sequencer
// Host-side sequencer for a firmware image transfer, one event per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries events: tuser holds the event code, tdata the event
//   arguments. Master stream carries results: tuser holds the action, tlast
//   marks the final result of an event, tdata the remaining result fields.
//   An event in the wrong mode, or with an unknown code, yields no result.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no event is in flight.
//   An accepted event waits in the input register until the output buffer has
//   room, and its results are registered into that buffer for the master stream.
//   Throughput: one event per cycle for single-result events while the master
//   stream is ready; a chunk request yields two results, which leave one at a
//   time through the single result port of the output buffer.
//   Reset: synchronous, active low; mode returns to idle, retry limit to 5,
//   start offset to 0, and both streams empty.
//   Stall: a held master tready fills the three-slot output buffer; from two
//   results on, the input register holds its event and drops s_axis_tready.
// ----------------------------------------------------------------------------
module firmware_update_host_sequencer (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [fuhs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [fuhs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // img_len[31:0], chunk_cap[47:32], client_node[111:48], ok_flag[112],
    // client_error[120:113], chunk_status[122:121]
    input  wire  [fuhs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func[3:0]
    input  wire  [fuhs_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // dest_node[63:0], chunk_offset[95:64], chunk_bytes[111:96],
    // error_code[114:112], reported_error[122:115], success[123],
    // ack_timer_cmd[125:124], beat_timer_cmd[127:126],
    // overall_timer_stop[128], mode[130:129]
    output logic [fuhs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // action[2:0]
    output logic [fuhs_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast
);
    import fuhs_pkg::*;

    logic     in_valid;
    t_in_item in_item;
    logic     room;
    logic     fire;
    t_push    push;

    assign fire = in_valid && room;

    fuhs_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (fire),
        .o_valid       (in_valid),
        .o_item        (in_item)
    );

    fuhs_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (in_item),
        .o_push     (push)
    );

    fuhs_out_queue u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_room        (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> rtl/core/fuhs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuhs_checker
// Port-level checks of the firmware update sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fuhs_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                m_axis_tvalid,
    input  wire                                m_axis_tready,
    input  wire  [fuhs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire  [fuhs_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    input  wire                                m_axis_tlast
);
    import fuhs_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present straight after reset");

    a_chunk_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_HEARTBEAT && !m_axis_tlast
        |=> m_axis_tvalid)
        else $error("chunk result missing after heartbeat");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_ERROR
        |-> m_axis_tdata[114:112] != ERR_NONE && m_axis_tdata[130:129] == MODE_ERR
            && m_axis_tlast)
        else $error("error result without code, error mode or end mark");

    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_ERROR |-> m_axis_tdata[114:112] == ERR_NONE)
        else $error("error code on a non-error result");

endmodule

bind firmware_update_host_sequencer fuhs_checker u_fuhs_checker (.*);
`default_nettype wire

>>> sim/firmware_update_host_sequencer_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_update_host_sequencer_chk
// Watches the event, result and configuration ports of the update sequencer.
// Keeps its own copy of the sequencer state. For every accepted event it
// works out the results the block owes. Each accepted result is compared,
// field by field, with the oldest of those.
// ----------------------------------------------------------------------------
module firmware_update_host_sequencer_chk (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [fuhs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [fuhs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                s_axis_tvalid,
    input  wire                                s_axis_tready,
    // img_len[31:0], chunk_cap[47:32], client_node[111:48], ok_flag[112],
    // client_error[120:113], chunk_status[122:121]
    input  wire  [fuhs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func[3:0]
    input  wire  [fuhs_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  wire                                m_axis_tvalid,
    input  wire                                m_axis_tready,
    // dest_node[63:0], chunk_offset[95:64], chunk_bytes[111:96],
    // error_code[114:112], reported_error[122:115], success[123],
    // ack_timer_cmd[125:124], beat_timer_cmd[127:126],
    // overall_timer_stop[128], mode[130:129]
    input  wire  [fuhs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // action[2:0]
    input  wire  [fuhs_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    input  wire                                m_axis_tlast,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_event_count
);
    import fuhs_pkg::*;

    t_result     owed_results[$];
    int          n_fail = 0;
    int          n_events = 0;

    logic [7:0]  retry_limit;
    logic [31:0] base_offset;
    logic [1:0]  seq_mode;
    logic [7:0]  retries;
    logic [31:0] image_bytes;
    logic [31:0] bytes_left;
    logic [15:0] chunk_max;
    logic [15:0] chunk_pending;
    logic [63:0] node;

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            n_fail++;
        end
    endtask

    task automatic raise_fault(input logic [2:0] code, input logic [7:0] rep,
                               input logic [1:0] ack, input logic [1:0] beat,
                               inout t_result r);
        seq_mode         = MODE_ERR;
        r.action         = ACT_ERROR;
        r.error_code     = code;
        r.reported_error = rep;
        r.ack_timer_cmd  = ack;
        r.beat_timer_cmd = beat;
    endtask

    task automatic predict_actions(input t_in_item ev);
        t_result     r;
        logic        hit;
        logic [15:0] len;
        r   = '0;
        hit = 1'b0;
        if (ev.func == FUNC_START) begin
            if (seq_mode == MODE_IDLE || seq_mode == MODE_ERR) begin
                hit           = 1'b1;
                image_bytes   = ev.img_len;
                chunk_max     = ev.chunk_cap;
                node          = ev.client_node;
                bytes_left    = ev.img_len;
                chunk_pending = '0;
                retries       = '0;
                seq_mode      = MODE_REQ;
                r.action        = ACT_REQUEST;
                r.dest_node     = node;
                r.ack_timer_cmd = TMR_START;
            end
        end else if (seq_mode == MODE_REQ) begin
            case (ev.func)
                FUNC_ACK: begin
                    hit = 1'b1;
                    if (ev.ok_flag) begin
                        seq_mode         = MODE_UPD;
                        r.ack_timer_cmd  = TMR_STOP;
                        r.beat_timer_cmd = TMR_START;
                    end else begin
                        raise_fault(ERR_CLIENT, ev.client_error, TMR_STOP, TMR_KEEP, r);
                    end
                end
                FUNC_ACK_TIMEOUT: begin
                    hit = 1'b1;
                    if (retries != RETRY_MAX)
                        retries++;
                    if (retries >= retry_limit) begin
                        raise_fault(ERR_TIMEOUT, '0, TMR_STOP, TMR_KEEP, r);
                    end else begin
                        r.action        = ACT_REQUEST;
                        r.dest_node     = node;
                        r.ack_timer_cmd = TMR_START;
                    end
                end
                FUNC_ABORT: begin
                    hit = 1'b1;
                    raise_fault(ERR_TIMEOUT, '0, TMR_STOP, TMR_KEEP, r);
                end
                default: ;
            endcase
        end else if (seq_mode == MODE_UPD) begin
            case (ev.func)
                FUNC_CHUNK_REQ: begin
                    hit = 1'b1;
                    len = (bytes_left >= {16'd0, chunk_max}) ? chunk_max : bytes_left[15:0];
                    chunk_pending    = len;
                    r.action         = ACT_HEARTBEAT;
                    r.dest_node      = node;
                    r.beat_timer_cmd = TMR_STOP;
                    r.mode           = seq_mode;
                    owed_results.push_back(r);
                    r                = '0;
                    r.action         = ACT_CHUNK;
                    r.dest_node      = node;
                    r.chunk_offset   = base_offset + image_bytes - bytes_left;
                    r.chunk_bytes    = len;
                    r.beat_timer_cmd = TMR_START;
                end
                FUNC_CHUNK_STAT: begin
                    case (ev.chunk_status)
                        CST_SENT: begin
                            hit = 1'b1;
                            if (bytes_left >= {16'd0, chunk_pending})
                                bytes_left = bytes_left - {16'd0, chunk_pending};
                            else
                                bytes_left = '0;
                            chunk_pending = '0;
                        end
                        CST_FLASH_FAIL: begin
                            hit = 1'b1;
                            raise_fault(ERR_FLASH, '0, TMR_KEEP, TMR_STOP, r);
                        end
                        CST_SEND_FAIL: begin
                            hit = 1'b1;
                            raise_fault(ERR_SEND, '0, TMR_KEEP, TMR_STOP, r);
                        end
                        default: ;
                    endcase
                end
                FUNC_END: begin
                    hit                  = 1'b1;
                    seq_mode             = MODE_IDLE;
                    r.action             = ACT_FINISHED;
                    r.success            = ev.ok_flag;
                    r.beat_timer_cmd     = TMR_STOP;
                    r.overall_timer_stop = 1'b1;
                end
                FUNC_HEARTBEAT: begin
                    hit              = 1'b1;
                    r.beat_timer_cmd = TMR_START;
                end
                FUNC_BEAT_TMO: begin
                    hit = 1'b1;
                    raise_fault(ERR_TIMEOUT, '0, TMR_KEEP, TMR_STOP, r);
                end
                FUNC_ABORT: begin
                    hit              = 1'b1;
                    seq_mode         = MODE_IDLE;
                    r.action         = ACT_IDLE;
                    r.beat_timer_cmd = TMR_STOP;
                end
                default: ;
            endcase
        end
        if (hit) begin
            r.mode = seq_mode;
            r.last = 1'b1;
            owed_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result  got;
        t_result  want;
        t_in_item ev;
        if (!i_rst_n) begin
            retry_limit   = RETRY_RESET;
            base_offset   = '0;
            seq_mode      = MODE_IDLE;
            retries       = '0;
            image_bytes   = '0;
            bytes_left    = '0;
            chunk_max     = '0;
            chunk_pending = '0;
            node          = '0;
            owed_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.action             = m_axis_tuser;
                got.last               = m_axis_tlast;
                got.dest_node          = m_axis_tdata[63:0];
                got.chunk_offset       = m_axis_tdata[95:64];
                got.chunk_bytes        = m_axis_tdata[111:96];
                got.error_code         = m_axis_tdata[114:112];
                got.reported_error     = m_axis_tdata[122:115];
                got.success            = m_axis_tdata[123];
                got.ack_timer_cmd      = m_axis_tdata[125:124];
                got.beat_timer_cmd     = m_axis_tdata[127:126];
                got.overall_timer_stop = m_axis_tdata[128];
                got.mode               = m_axis_tdata[130:129];
                if (owed_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual action %0d",
                             $time, got.action);
                    n_fail++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("action", 64'(want.action), 64'(got.action));
                    check_field("last", 64'(want.last), 64'(got.last));
                    check_field("dest_node", want.dest_node, got.dest_node);
                    check_field("chunk_offset", 64'(want.chunk_offset),
                                64'(got.chunk_offset));
                    check_field("chunk_bytes", 64'(want.chunk_bytes),
                                64'(got.chunk_bytes));
                    check_field("error_code", 64'(want.error_code), 64'(got.error_code));
                    check_field("reported_error", 64'(want.reported_error),
                                64'(got.reported_error));
                    check_field("success", 64'(want.success), 64'(got.success));
                    check_field("ack_timer_cmd", 64'(want.ack_timer_cmd),
                                64'(got.ack_timer_cmd));
                    check_field("beat_timer_cmd", 64'(want.beat_timer_cmd),
                                64'(got.beat_timer_cmd));
                    check_field("overall_timer_stop", 64'(want.overall_timer_stop),
                                64'(got.overall_timer_stop));
                    check_field("mode", 64'(want.mode), 64'(got.mode));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ev.func         = s_axis_tuser;
                ev.img_len      = s_axis_tdata[31:0];
                ev.chunk_cap    = s_axis_tdata[47:32];
                ev.client_node  = s_axis_tdata[111:48];
                ev.ok_flag      = s_axis_tdata[112];
                ev.client_error = s_axis_tdata[120:113];
                ev.chunk_status = s_axis_tdata[122:121];
                predict_actions(ev);
                n_events++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_ACK_RETRIES)
                    retry_limit = i_cfg_data[7:0];
                else if (i_cfg_idx == CFG_IMAGE_START_OFFSET)
                    base_offset = i_cfg_data[31:0];
            end
        end
        o_fail_count  <= n_fail;
        o_pending     <= owed_results.size();
        o_event_count <= n_events;
    end

endmodule

>>> sim/firmware_update_host_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_update_host_sequencer_tb
// Drives the update sequencer with a short directed run through most events
// and corner cases. Then come six randomised phases of mostly well-formed
// transfers, with some noise mixed in. Each phase uses its own retry limit
// and start offset. Both streams idle at random. One phase runs without
// gaps, and one holds the result stream off long enough to back-pressure the
// event stream. The checker instance does all the prediction and comparison.
// ----------------------------------------------------------------------------
module firmware_update_host_sequencer_tb;
    import fuhs_pkg::*;

    localparam logic [3:0] FUNC_UNKNOWN = 4'hF;
    localparam logic [1:0] CST_UNKNOWN  = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    wire  [OUT_USER_W-1:0] m_axis_tuser;
    wire                   m_axis_tlast;

    int fail_count;
    int pending;
    int event_count;
    bit flow_calm = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    firmware_update_host_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    firmware_update_host_sequencer_chk chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_event_count (event_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= flow_calm || ($urandom_range(0, 99) >= 18);
        end
    end

    function automatic t_in_item event_of(input logic [3:0] func);
        t_in_item ev;
        ev.func         = func;
        ev.img_len      = $urandom;
        ev.chunk_cap    = 16'($urandom);
        ev.client_node  = {$urandom, $urandom};
        ev.ok_flag      = 1'($urandom);
        ev.client_error = 8'($urandom);
        ev.chunk_status = 2'($urandom_range(0, 3));
        return ev;
    endfunction

    task automatic send_event(input t_in_item ev);
        while (!flow_calm && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.func;
        s_axis_tdata  <= {5'd0, ev.chunk_status, ev.client_error, ev.ok_flag,
                          ev.client_node, ev.chunk_cap, ev.img_len};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_transfer();
        t_in_item ev;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            repeat ($urandom_range(1, 4))
                send_event(event_of(4'($urandom_range(0, 15))));
            return;
        end
        ev = event_of(FUNC_START);
        ev.chunk_cap = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 64));
        if ($urandom_range(0, 9) != 0)
            ev.img_len = $urandom_range(0, 400);
        send_event(ev);
        repeat ($urandom_range(0, 3))
            send_event(event_of(FUNC_ACK_TIMEOUT));
        ev = event_of(FUNC_ACK);
        ev.ok_flag = ($urandom_range(0, 9) != 0);
        send_event(ev);
        repeat ($urandom_range(1, 6)) begin
            send_event(event_of(FUNC_CHUNK_REQ));
            if ($urandom_range(0, 4) == 0)
                send_event(event_of(FUNC_HEARTBEAT));
            ev = event_of(FUNC_CHUNK_STAT);
            ev.chunk_status = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3))
                                                           : CST_SENT;
            send_event(ev);
        end
        roll = $urandom_range(0, 9);
        if (roll < 7)
            send_event(event_of(FUNC_END));
        else if (roll == 7)
            send_event(event_of(FUNC_ABORT));
        else if (roll == 8)
            send_event(event_of(FUNC_BEAT_TMO));
    endtask

    initial begin : stimulus
        t_in_item    ev;
        int          goal;
        logic [31:0] retry_word;
        logic [31:0] offset_word;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed run on reset configuration
        send_event(event_of(FUNC_ACK));
        ev = event_of(FUNC_START);
        ev.img_len     = '1;
        ev.chunk_cap   = '1;
        ev.client_node = '1;
        send_event(ev);
        send_event(event_of(FUNC_ACK_TIMEOUT));
        ev = event_of(FUNC_ACK);
        ev.ok_flag      = 1'b0;
        ev.client_error = 8'hFF;
        send_event(ev);
        ev = event_of(FUNC_START);
        ev.img_len     = '0;
        ev.chunk_cap   = 16'd1;
        ev.client_node = '0;
        send_event(ev);
        send_event(event_of(FUNC_ABORT));
        ev = event_of(FUNC_START);
        ev.img_len   = 32'd10;
        ev.chunk_cap = 16'd4;
        send_event(ev);
        ev = event_of(FUNC_ACK);
        ev.ok_flag = 1'b1;
        send_event(ev);
        send_event(event_of(FUNC_HEARTBEAT));
        repeat (4) begin
            send_event(event_of(FUNC_CHUNK_REQ));
            ev = event_of(FUNC_CHUNK_STAT);
            ev.chunk_status = CST_SENT;
            send_event(ev);
        end
        ev = event_of(FUNC_CHUNK_STAT);
        ev.chunk_status = CST_UNKNOWN;
        send_event(ev);
        send_event(event_of(FUNC_UNKNOWN));
        ev = event_of(FUNC_END);
        ev.ok_flag = 1'b0;
        send_event(ev);
        ev = event_of(FUNC_START);
        ev.img_len   = 32'd20;
        ev.chunk_cap = 16'hFFFF;
        send_event(ev);
        ev = event_of(FUNC_ACK);
        ev.ok_flag = 1'b1;
        send_event(ev);
        send_event(event_of(FUNC_CHUNK_REQ));
        ev = event_of(FUNC_CHUNK_STAT);
        ev.chunk_status = CST_FLASH_FAIL;
        send_event(ev);
        send_event(event_of(FUNC_START));
        ev = event_of(FUNC_ACK);
        ev.ok_flag = 1'b1;
        send_event(ev);
        send_event(event_of(FUNC_ABORT));

        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            retry_word  = $urandom;
            offset_word = $urandom;
            case (phase)
                0: begin
                    retry_word[7:0] = 8'd0;
                    offset_word     = '1;
                end
                1: begin
                    retry_word[7:0] = 8'd255;
                    offset_word     = '0;
                end
                2: retry_word[7:0] = 8'd1;
                3: retry_word[7:0] = 8'($urandom_range(1, 8));
                4: begin
                    retry_word[7:0] = 8'd2;
                    offset_word     = 32'hFFFF_FF00;
                end
                default: retry_word[7:0] = 8'($urandom_range(1, 255));
            endcase
            write_reg(CFG_MAX_ACK_RETRIES, retry_word);
            write_reg(CFG_IMAGE_START_OFFSET, offset_word);
            flow_calm = (phase == 2);
            if (phase == 3)
                hold_req = 1'b1;
            goal = event_count + 300;
            while (event_count < goal)
                run_transfer();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> firmware_update_host_sequencer.f
rtl/core/fuhs_pkg.sv
rtl/core/fuhs_in_stage.sv
rtl/core/fuhs_step.sv
rtl/core/fuhs_out_queue.sv
rtl/core/firmware_update_host_sequencer.sv
rtl/core/fuhs_checker.sv
sim/firmware_update_host_sequencer_chk.sv
sim/firmware_update_host_sequencer_tb.sv
